// File: rtl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared widths, codes and types of the sleeper timeout table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  localparam int OP_W      = 2;
  localparam int ID_W      = 8;
  localparam int COUNT_W   = 31;
  localparam int ELAPSED_W = 5;
  localparam int KIND_W    = 2;

  // depth of the command queue between front and back
  localparam int Q_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_JOIN  = 2'd0,
    OP_LEAVE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_JOIN  = 2'd0,
    KIND_LEAVE = 2'd1,
    KIND_FIRED = 2'd2
  } kind_t;

  typedef struct packed {
    op_t                  op;
    logic [ID_W-1:0]      id;
    logic [COUNT_W-1:0]   count;
    logic [ELAPSED_W-1:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [ID_W-1:0] waiter;
    logic            ok;
    logic            last;
  } rsp_t;

endpackage

// File: rtl/stt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_front
// Takes input words, masks the id and drops unused op codes before queuing.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int ID_BITS = 8
) (
  input  logic                             start,
  input  logic [stt_pkg::OP_W-1:0]         in_op,
  input  logic [stt_pkg::ID_W-1:0]         in_waiter_id,
  input  logic [stt_pkg::COUNT_W-1:0]      in_sleep_count,
  input  logic [stt_pkg::ELAPSED_W-1:0]    in_elapsed,
  input  logic                             q_full,
  output logic                             busy,
  output logic                             push,
  output stt_pkg::cmd_t                    push_cmd
);
  import stt_pkg::*;

  localparam logic [ID_W-1:0] ID_MASK =
    (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_BITS) - 1);

  op_t op_s;

  assign op_s = op_t'(in_op);
  assign busy = q_full;

  // unused op code is accepted and dropped here
  assign push = start && !q_full && (op_s != OP_NONE);

  always_comb begin
    push_cmd.op      = op_s;
    push_cmd.id      = in_waiter_id & ID_MASK;
    push_cmd.count   = in_sleep_count;
    push_cmd.elapsed = in_elapsed;
  end

endmodule

// File: rtl/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue
// Short command queue that decouples the front from the table sequencer.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stt_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output stt_pkg::cmd_t head
);
  import stt_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(Q_DEPTH - 1);

  cmd_t             buf_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = buf_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_END) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_END) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/stt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_back
// Table sequencer: scans the slot memory once per command, one slot a cycle.
// ----------------------------------------------------------------------------
module stt_back #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  stt_pkg::cmd_t q_head,
  output logic          pop,
  output stt_pkg::rsp_t rsp
);
  import stt_pkg::*;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DIFF_W = COUNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [ID_BITS-1:0] waiter;
    logic [COUNT_W-1:0] rem;
  } entry_t;

  entry_t             mem [SLOTS];
  entry_t             rd_ent_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [IDX_W-1:0]   iss_idx_r, iss_idx_nxt;
  logic               iss_on_r, iss_on_nxt;
  logic [IDX_W-1:0]   s2_idx_r, s2_idx_nxt;
  logic               s2_on_r, s2_on_nxt;
  logic               s2_last_r, s2_last_nxt;
  logic               match_r, match_nxt;
  logic [IDX_W-1:0]   match_idx_r, match_idx_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [ID_BITS-1:0] pend_id_r, pend_id_nxt;
  rsp_t               rsp_r, rsp_nxt;

  logic [ID_BITS-1:0] cmd_id_s;
  logic [DIFF_W-1:0]  diff;
  logic               slot_live;
  logic               hit;

  assign rsp      = rsp_r;
  assign cmd_id_s = ID_BITS'(cmd_r.id);
  assign diff     = {1'b0, rd_ent_r.rem} - DIFF_W'(cmd_r.elapsed);
  assign slot_live = valid_r[s2_idx_r];
  assign hit      = slot_live && (rd_ent_r.waiter == cmd_id_s);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    valid_nxt     = valid_r;
    iss_idx_nxt   = iss_idx_r;
    iss_on_nxt    = iss_on_r;
    s2_idx_nxt    = s2_idx_r;
    s2_on_nxt     = 1'b0;
    s2_last_nxt   = 1'b0;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    rsp_nxt       = '0;
    mem_we        = 1'b0;
    mem_wa        = s2_idx_r;
    mem_wd        = rd_ent_r;
    pop           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop         = 1'b1;
          cmd_nxt     = q_head;
          iss_idx_nxt = '0;
          iss_on_nxt  = 1'b1;
          match_nxt   = 1'b0;
          free_nxt    = 1'b0;
          pend_nxt    = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue stage: read address walks the slots
        s2_on_nxt   = iss_on_r;
        s2_idx_nxt  = iss_idx_r;
        s2_last_nxt = (iss_idx_r == LAST_IDX);
        if (iss_on_r) begin
          if (iss_idx_r == LAST_IDX) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_idx_nxt = iss_idx_r + 1'b1;
          end
        end

        // evaluate stage: works on the slot read last cycle
        if (s2_on_r) begin
          case (cmd_r.op)
            OP_JOIN: begin
              if (hit && !match_r) begin
                match_nxt     = 1'b1;
                match_idx_nxt = s2_idx_r;
              end
              if (!slot_live && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = s2_idx_r;
              end
            end
            OP_LEAVE: begin
              if (hit) begin
                valid_nxt[s2_idx_r] = 1'b0;
              end
            end
            OP_TICK: begin
              if (slot_live) begin
                mem_we     = 1'b1;
                mem_wd.rem = diff[COUNT_W-1:0];
                if (diff[COUNT_W]) begin
                  valid_nxt[s2_idx_r] = 1'b0;
                  // earlier fired slot goes out now, this one waits
                  if (pend_r) begin
                    rsp_nxt.valid  = 1'b1;
                    rsp_nxt.kind   = KIND_FIRED;
                    rsp_nxt.waiter = ID_W'(pend_id_r);
                    rsp_nxt.ok     = 1'b1;
                    rsp_nxt.last   = 1'b0;
                  end
                  pend_nxt    = 1'b1;
                  pend_id_nxt = rd_ent_r.waiter;
                end
              end
            end
            default: begin
            end
          endcase
          if (s2_last_r) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        state_nxt = ST_IDLE;
        case (cmd_r.op)
          OP_JOIN: begin
            rsp_nxt.valid  = 1'b1;
            rsp_nxt.kind   = KIND_JOIN;
            rsp_nxt.waiter = cmd_r.id;
            rsp_nxt.last   = 1'b1;
            rsp_nxt.ok     = match_r || free_r;
            if (match_r || free_r) begin
              mem_we            = 1'b1;
              mem_wa            = match_r ? match_idx_r : free_idx_r;
              mem_wd.waiter     = cmd_id_s;
              mem_wd.rem        = cmd_r.count;
              valid_nxt[mem_wa] = 1'b1;
            end
          end
          OP_LEAVE: begin
            rsp_nxt.valid  = 1'b1;
            rsp_nxt.kind   = KIND_LEAVE;
            rsp_nxt.waiter = cmd_r.id;
            rsp_nxt.ok     = 1'b1;
            rsp_nxt.last   = 1'b1;
          end
          OP_TICK: begin
            if (pend_r) begin
              rsp_nxt.valid  = 1'b1;
              rsp_nxt.kind   = KIND_FIRED;
              rsp_nxt.waiter = ID_W'(pend_id_r);
              rsp_nxt.ok     = 1'b1;
              rsp_nxt.last   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      iss_on_r  <= 1'b0;
      s2_on_r   <= 1'b0;
      s2_last_r <= 1'b0;
      match_r   <= 1'b0;
      free_r    <= 1'b0;
      pend_r    <= 1'b0;
      rsp_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      iss_on_r  <= iss_on_nxt;
      s2_on_r   <= s2_on_nxt;
      s2_last_r <= s2_last_nxt;
      match_r   <= match_nxt;
      free_r    <= free_nxt;
      pend_r    <= pend_nxt;
      rsp_r     <= rsp_nxt;
    end
    cmd_r       <= cmd_nxt;
    iss_idx_r   <= iss_idx_nxt;
    s2_idx_r    <= s2_idx_nxt;
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    pend_id_r   <= pend_id_nxt;
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (iss_on_r) begin
      rd_ent_r <= mem[iss_idx_r];
    end
  end

`ifndef SYNTHESIS
  a_join_leave_last: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_r.valid && (rsp_r.kind == KIND_JOIN || rsp_r.kind == KIND_LEAVE) |-> rsp_r.last)
    else $error("join or leave answer without last");

  a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_r.valid |-> ($past(state_r) == ST_SCAN || $past(state_r) == ST_FIN))
    else $error("result raised outside scan or finish");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s2_on_r |-> state_r == ST_SCAN)
    else $error("evaluate stage active outside scan");

  a_fin_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> state_r == ST_IDLE)
    else $error("finish state held");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ST_IDLE && !q_empty)
    else $error("queue popped while busy");
`endif

endmodule

// File: rtl/sleeper_timeout_table_unit.sv
`timescale 1ns / 1ps
// join and leave answers are registered in the finish state after the slot scan;
// a tick emits fired waiters during its scan and the last one at its end.
// every command runs once through the slot scanner, one slot per cycle
// through the single read port of the slot memory; a two-word queue in front
// lets busy stay low while a command is scanned. results cannot be stalled.
// reset empties the table and the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
// sleeper_timeout_table_unit
// Table of sleeping waiters with join, leave and tick commands.
// ----------------------------------------------------------------------------
module sleeper_timeout_table_unit #(
  parameter int SLOTS   = stt_pkg::SLOTS_DEF,
  parameter int ID_BITS = stt_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [stt_pkg::OP_W-1:0]      in_op,
  input  logic [stt_pkg::ID_W-1:0]      in_waiter_id,
  input  logic [stt_pkg::COUNT_W-1:0]   in_sleep_count,
  input  logic [stt_pkg::ELAPSED_W-1:0] in_elapsed,
  output logic                          out_valid,
  output logic [stt_pkg::KIND_W-1:0]    out_kind,
  output logic [stt_pkg::ID_W-1:0]      out_waiter_out,
  output logic                          out_ok,
  output logic                          out_last
);
  import stt_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_head;
  rsp_t rsp;

  stt_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .start          (start),
    .in_op          (in_op),
    .in_waiter_id   (in_waiter_id),
    .in_sleep_count (in_sleep_count),
    .in_elapsed     (in_elapsed),
    .q_full         (q_full),
    .busy           (busy),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  stt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  stt_back #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .rsp     (rsp)
  );

  assign out_valid      = rsp.valid;
  assign out_kind       = rsp.kind;
  assign out_waiter_out = rsp.waiter;
  assign out_ok         = rsp.ok;
  assign out_last       = rsp.last;

endmodule

// File: test/sleeper_timeout_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sleeper_timeout_table_unit_tb
// Drives join, leave, tick and unused words through the command port, first
// from a short directed table and then at random in bursts with gaps, and
// checks every result word against a slot-by-slot model of the waiter table.
// ----------------------------------------------------------------------------
module sleeper_timeout_table_unit_tb;
  import stt_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int SCAN_CYCLES  = SLOTS + 3;
  localparam int RANDOM_WORDS = 500;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] waiter;
    logic            ok;
    logic            last;
  } result_t;

  typedef struct {
    op_t                  op;
    logic [ID_W-1:0]      id;
    logic [COUNT_W-1:0]   cnt;
    logic [ELAPSED_W-1:0] el;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_op = '0;
  logic [ID_W-1:0]      in_waiter_id = '0;
  logic [COUNT_W-1:0]   in_sleep_count = '0;
  logic [ELAPSED_W-1:0] in_elapsed = '0;
  logic                 out_valid;
  logic [KIND_W-1:0]    out_kind;
  logic [ID_W-1:0]      out_waiter_out;
  logic                 out_ok;
  logic                 out_last;

  // table model
  bit              slot_live [SLOTS];
  logic [ID_W-1:0] slot_id   [SLOTS];
  longint          slot_left [SLOTS];

  result_t   step_results[$];
  result_t   awaited_results[$];
  stim_row_t directed_rows[$];
  int        fault_count = 0;
  int        burst_left = 0;

  sleeper_timeout_table_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_waiter_id   (in_waiter_id),
    .in_sleep_count (in_sleep_count),
    .in_elapsed     (in_elapsed),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_waiter_out (out_waiter_out),
    .out_ok         (out_ok),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int find_slot(input logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_id[i] == id) return i;
    end
    return -1;
  endfunction

  // id is left as it is when the table is empty
  function automatic bit pick_live(inout logic [ID_W-1:0] id);
    int n;
    int k;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_live[i]) n++;
    if (n == 0) return 1'b0;
    k = $urandom_range(n - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) begin
        if (k == 0) id = slot_id[i];
        k--;
      end
    end
    return 1'b1;
  endfunction

  // works out the result words of one accepted word and updates the table
  task automatic advance_table(input op_t op, input logic [ID_W-1:0] id,
                               input logic [COUNT_W-1:0] cnt,
                               input logic [ELAPSED_W-1:0] el);
    int      hit;
    result_t r;
    step_results.delete();
    case (op)
      OP_JOIN: begin
        hit = find_slot(id);
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && !slot_live[i]) hit = i;
        end
        r = '{KIND_JOIN, id, (hit >= 0), 1'b1};
        if (hit >= 0) begin
          slot_live[hit] = 1'b1;
          slot_id[hit]   = id;
          slot_left[hit] = longint'(cnt);
        end
        step_results.push_back(r);
      end
      OP_LEAVE: begin
        hit = find_slot(id);
        if (hit >= 0) slot_live[hit] = 1'b0;
        r = '{KIND_LEAVE, id, 1'b1, 1'b1};
        step_results.push_back(r);
      end
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            slot_left[i] = slot_left[i] - longint'(el);
            if (slot_left[i] < 0) begin
              r = '{KIND_FIRED, slot_id[i], 1'b1, 1'b0};
              step_results.push_back(r);
              slot_live[i] = 1'b0;
            end
          end
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // sender bursts: a random gap opens each new burst
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 30) : $urandom_range(8, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(input op_t op, input logic [ID_W-1:0] id,
                           input logic [COUNT_W-1:0] cnt,
                           input logic [ELAPSED_W-1:0] el,
                           input bit typed, input result_t want);
    start          <= 1'b1;
    in_op          <= op;
    in_waiter_id   <= id;
    in_sleep_count <= cnt;
    in_elapsed     <= el;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    advance_table(op, id, cnt, el);
    if (typed) awaited_results.push_back(want);
    else foreach (step_results[k]) awaited_results.push_back(step_results[k]);
  endtask

  function automatic void add_row(input op_t op, input logic [ID_W-1:0] id,
                                  input logic [COUNT_W-1:0] cnt,
                                  input logic [ELAPSED_W-1:0] el,
                                  input bit typed, input result_t want);
    stim_row_t row;
    row.op    = op;
    row.id    = id;
    row.cnt   = cnt;
    row.el    = el;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (awaited_results.size() == 0) begin
        report_fault($sformatf("unexpected word: kind %0d waiter %0d ok %0d last %0d",
                               out_kind, out_waiter_out, out_ok, out_last));
      end else begin
        want = awaited_results.pop_front();
        if (out_valid !== 1'b1 || out_kind !== want.kind || out_waiter_out !== want.waiter ||
            out_ok !== want.ok || out_last !== want.last) begin
          report_fault($sformatf(
            "mismatch: kind %0d/%0d waiter %0d/%0d ok %0d/%0d last %0d/%0d (exp/act)",
            want.kind, out_kind, want.waiter, out_waiter_out,
            want.ok, out_ok, want.last, out_last));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("sleeper_timeout_table_unit_tb: errors");
    $finish;
  end

  initial begin
    op_t                  op;
    logic [ID_W-1:0]      id;
    logic [COUNT_W-1:0]   cnt;
    logic [ELAPSED_W-1:0] el;
    logic [31:0]          rnd;
    int                   pick;
    int                   sent;

    // leave on an empty table, joins at the id and count extremes, replace
    add_row(OP_LEAVE, 8'd0, '0, '0, 1'b1, '{KIND_LEAVE, 8'd0, 1'b1, 1'b1});
    add_row(OP_JOIN, 8'd255, '0, '0, 1'b1, '{KIND_JOIN, 8'd255, 1'b1, 1'b1});
    add_row(OP_JOIN, 8'd0, '1, '0, 1'b1, '{KIND_JOIN, 8'd0, 1'b1, 1'b1});
    add_row(OP_JOIN, 8'd255, 31'd5, '0, 1'b1, '{KIND_JOIN, 8'd255, 1'b1, 1'b1});
    // zero elapsed fires nothing, then the widest elapsed value
    add_row(OP_TICK, 8'd0, '0, 5'd0, 1'b0, '0);
    add_row(OP_TICK, 8'd0, '0, 5'd31, 1'b0, '0);
    add_row(OP_NONE, 8'haa, 31'h2aaaaaaa, 5'h15, 1'b0, '0);
    // fill the table, then a join that finds no room and one that replaces
    for (int i = 1; i <= SLOTS - 1; i++) begin
      add_row(OP_JOIN, ID_W'(i * 17), COUNT_W'(i % 5), '0, 1'b1,
              '{KIND_JOIN, ID_W'(i * 17), 1'b1, 1'b1});
    end
    add_row(OP_JOIN, 8'h80, 31'd1, '0, 1'b1, '{KIND_JOIN, 8'h80, 1'b0, 1'b1});
    add_row(OP_JOIN, 8'd0, 31'd3, '0, 1'b1, '{KIND_JOIN, 8'd0, 1'b1, 1'b1});
    add_row(OP_LEAVE, 8'd17, '0, '0, 1'b1, '{KIND_LEAVE, 8'd17, 1'b1, 1'b1});
    add_row(OP_TICK, 8'd0, '0, 5'd16, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      pace();
      send_word(directed_rows[r].op, directed_rows[r].id, directed_rows[r].cnt,
                directed_rows[r].el, directed_rows[r].typed, directed_rows[r].want);
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      rnd  = $urandom;
      id   = ID_W'($urandom_range(255));
      cnt  = rnd[COUNT_W-1:0];
      el   = ELAPSED_W'($urandom_range(16, 1));
      if (pick < 40) begin
        op = OP_JOIN;
        if ($urandom_range(9) < 4) void'(pick_live(id));
        case ($urandom_range(9))
          7, 8:    cnt = COUNT_W'($urandom_range(100));
          9:       ;
          default: cnt = COUNT_W'($urandom_range(20));
        endcase
      end else if (pick < 60) begin
        op = OP_LEAVE;
        if ($urandom_range(9) < 7) void'(pick_live(id));
      end else if (pick < 95) begin
        op = OP_TICK;
        case ($urandom_range(9))
          0:       el = 5'd0;
          1:       el = ELAPSED_W'($urandom_range(31, 17));
          default: ;
        endcase
      end else begin
        op = OP_NONE;
        el = ELAPSED_W'($urandom);
      end
      pace();
      send_word(op, id, cnt, el, 1'b0, '0);
      if (op != OP_NONE) sent++;
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    // catch stray words from a scan still in flight
    repeat (3 * SCAN_CYCLES + 8) @(posedge clk);

    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("sleeper_timeout_table_unit_tb: clean");
    end else begin
      $display("sleeper_timeout_table_unit_tb: errors");
    end
    $finish;
  end

endmodule
